// ===== rtl/pcrq_pkg.sv =====
package pcrq_pkg;

    // field widths fixed by the request and response formats
    localparam int OPCODE_W = 2;
    localparam int CID_W    = 6;
    localparam int RID_W    = 32;
    localparam int SIZE_W   = 16;
    localparam int COUNT_W  = 7;
    localparam int QBYTES_W = 22;
    localparam int TOTAL_W  = 23;

    // slot storage
    localparam int NUM_CLIENTS = 64;
    localparam int CLIENT_W    = $clog2(NUM_CLIENTS);
    localparam int LINK_W      = CLIENT_W + 1;
    localparam logic [LINK_W-1:0] LINK_NIL = LINK_W'(NUM_CLIENTS);

    typedef enum logic [OPCODE_W-1:0] {
        OP_APPEND = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LINK,
        ST_TERM,
        ST_DONE
    } state_t;

    typedef struct packed {
        opcode_t             opcode;
        logic [CID_W-1:0]    client;
        logic [RID_W-1:0]    rid;
        logic [SIZE_W-1:0]   request_size;
    } req_t;

    typedef struct packed {
        logic                accepted;
        logic                item_valid;
        logic [CID_W-1:0]    item_client;
        logic [RID_W-1:0]    item_rid;
        logic [SIZE_W-1:0]   item_size;
        logic                removed_head;
        logic [COUNT_W-1:0]  queue_count;
        logic [QBYTES_W-1:0] queue_bytes;
    } rsp_t;

    typedef struct packed {
        logic [RID_W-1:0]    rid;
        logic [SIZE_W-1:0]   size;
    } slot_data_t;

    function automatic logic is_slot(input logic [LINK_W-1:0] idx);
        return idx < LINK_W'(NUM_CLIENTS);
    endfunction

endpackage

// ===== rtl/pcrq_ram.sv =====
module pcrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/per_client_request_queue_unit.sv =====
// Per-client request queue: holds at most one pending request per client, in
// arrival order, as a doubly linked list threaded through per-client slots.
// Opcodes: append (replaces a held request only if the new id is strictly
// greater, moving it to the tail), pop head, remove a client's request whose id
// is at most the given id, and clear all. Every request yields exactly one
// response carrying the queue count and byte total after the operation.
// Requests are handled one at a time. Clear and a no-op decided at once (empty
// pop, remove on an empty slot, out-of-range client) go straight to the done
// state; a pop, any remove that finds the slot held (hit or miss) and an append
// rejected on its id pass through the read state, an append to an empty slot
// through the link and term states, and an append that replaces an older
// request through read, link and term. A response still stalled from the
// previous request holds the done state until it leaves. The next request is
// taken in the cycle after the response is registered, even while that response
// is still stalled. The state sequence is set by the slot memories: the stored
// id and links arrive in the cycle after the read, and the link rewrites of an
// unlink and of a tail insert go out one per memory write port per cycle. Slot
// occupancy bits are flops, so reset and clear take effect at once with no sweep.
module per_client_request_queue_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  pcrq_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output pcrq_pkg::rsp_t rsp
);

    import pcrq_pkg::*;

    // control and list state
    state_t                  state_reg,   state_next;
    logic [NUM_CLIENTS-1:0]  valid_reg,   valid_next;
    logic [LINK_W-1:0]       head_reg,    head_next;
    logic [LINK_W-1:0]       tail_reg,    tail_next;
    logic [COUNT_W-1:0]      count_reg,   count_next;
    logic [TOTAL_W-1:0]      bytes_reg,   bytes_next;
    logic                    out_valid_reg, out_valid_next;

    // request being worked on and its partial response
    opcode_t                 op_reg,      op_next;
    logic [CLIENT_W-1:0]     tgt_reg,     tgt_next;
    logic [RID_W-1:0]        rid_reg,     rid_next;
    logic [SIZE_W-1:0]       size_reg,    size_next;
    rsp_t                    res_reg,     res_next;
    rsp_t                    out_reg,     out_next;

    // slot memory ports
    logic                    data_we;
    logic [CLIENT_W-1:0]     data_waddr;
    slot_data_t              data_wdata;
    slot_data_t              data_rdata;
    logic                    next_we;
    logic [CLIENT_W-1:0]     next_waddr;
    logic [LINK_W-1:0]       next_wdata;
    logic [LINK_W-1:0]       next_rdata;
    logic                    prev_we;
    logic [CLIENT_W-1:0]     prev_waddr;
    logic [LINK_W-1:0]       prev_wdata;
    logic [LINK_W-1:0]       prev_rdata;
    logic [CLIENT_W-1:0]     raddr;

    // unlink decision in the read cycle
    logic                    do_unlink;
    logic                    cid_ok;
    logic                    head_ok;

    // rid and size of each slot
    pcrq_ram #(
        .WIDTH ($bits(slot_data_t)),
        .DEPTH (NUM_CLIENTS)
    ) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (data_wdata),
        .raddr (raddr),
        .rdata (data_rdata)
    );

    // forward links, toward the tail
    pcrq_ram #(
        .WIDTH (LINK_W),
        .DEPTH (NUM_CLIENTS)
    ) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (raddr),
        .rdata (next_rdata)
    );

    // backward links, toward the head
    pcrq_ram #(
        .WIDTH (LINK_W),
        .DEPTH (NUM_CLIENTS)
    ) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .raddr (raddr),
        .rdata (prev_rdata)
    );

    // one request at a time; the output register frees the input side
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    assign cid_ok  = is_slot(LINK_W'(req.client));
    assign head_ok = is_slot(head_reg) && valid_reg[head_reg[CLIENT_W-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            head_reg      <= LINK_NIL;
            tail_reg      <= LINK_NIL;
            count_reg     <= '0;
            bytes_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            bytes_reg     <= bytes_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers need no reset
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        tgt_reg  <= tgt_next;
        rid_reg  <= rid_next;
        size_reg <= size_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        bytes_next     = bytes_reg;
        op_next        = op_reg;
        tgt_next       = tgt_reg;
        rid_next       = rid_reg;
        size_next      = size_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        // response leaves when the consumer takes it
        out_valid_next = out_valid_reg && rsp_stall;

        raddr      = tgt_reg;
        data_we    = 1'b0;
        data_waddr = tgt_reg;
        data_wdata = '{rid: rid_reg, size: size_reg};
        next_we    = 1'b0;
        next_waddr = tgt_reg;
        next_wdata = LINK_NIL;
        prev_we    = 1'b0;
        prev_waddr = tgt_reg;
        prev_wdata = LINK_NIL;
        do_unlink  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next   = req.opcode;
                    rid_next  = req.rid;
                    size_next = req.request_size;
                    tgt_next  = CLIENT_W'(req.client);
                    res_next  = '0;
                    state_next = ST_DONE;
                    unique case (req.opcode)
                        OP_APPEND:
                        begin
                            if (cid_ok)
                            begin
                                // held request must be compared before replacing
                                state_next = valid_reg[CLIENT_W'(req.client)]
                                             ? ST_READ : ST_LINK;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (cid_ok && valid_reg[CLIENT_W'(req.client)])
                            begin
                                state_next = ST_READ;
                            end
                        end
                        OP_POP:
                        begin
                            tgt_next = head_reg[CLIENT_W-1:0];
                            if (head_ok)
                            begin
                                state_next = ST_READ;
                            end
                        end
                        OP_CLEAR:
                        begin
                            valid_next = '0;
                            head_next  = LINK_NIL;
                            tail_next  = LINK_NIL;
                            count_next = '0;
                            bytes_next = '0;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                    raddr = tgt_next;
                end
            end

            ST_READ:
            begin
                // slot contents and links arrive here
                case (op_reg)
                    OP_APPEND: do_unlink = rid_reg > data_rdata.rid;
                    OP_REMOVE: do_unlink = data_rdata.rid <= rid_reg;
                    default:   do_unlink = 1'b1;
                endcase

                if (op_reg == OP_POP)
                begin
                    res_next.item_valid  = 1'b1;
                    res_next.item_client = CID_W'(tgt_reg);
                    res_next.item_rid    = data_rdata.rid;
                    res_next.item_size   = data_rdata.size;
                end

                state_next = ST_DONE;
                if (do_unlink)
                begin
                    valid_next[tgt_reg] = 1'b0;
                    count_next = count_reg - COUNT_W'(1);
                    bytes_next = bytes_reg - TOTAL_W'(data_rdata.size);

                    // splice out of the list
                    if (!is_slot(prev_rdata))
                    begin
                        head_next = is_slot(next_rdata) ? next_rdata : LINK_NIL;
                        if (op_reg == OP_REMOVE)
                        begin
                            res_next.removed_head = 1'b1;
                        end
                    end
                    else
                    begin
                        next_we    = 1'b1;
                        next_waddr = prev_rdata[CLIENT_W-1:0];
                        next_wdata = is_slot(next_rdata) ? next_rdata : LINK_NIL;
                    end

                    if (!is_slot(next_rdata))
                    begin
                        tail_next = is_slot(prev_rdata) ? prev_rdata : LINK_NIL;
                    end
                    else
                    begin
                        prev_we    = 1'b1;
                        prev_waddr = next_rdata[CLIENT_W-1:0];
                        prev_wdata = is_slot(prev_rdata) ? prev_rdata : LINK_NIL;
                    end

                    if (op_reg == OP_APPEND)
                    begin
                        state_next = ST_LINK;
                    end
                end
            end

            ST_LINK:
            begin
                // store the new request and hang it off the tail
                res_next.accepted   = 1'b1;
                valid_next[tgt_reg] = 1'b1;
                count_next = count_reg + COUNT_W'(1);
                bytes_next = bytes_reg + TOTAL_W'(size_reg);
                data_we    = 1'b1;
                prev_we    = 1'b1;
                prev_waddr = tgt_reg;
                if (!is_slot(tail_reg) || !is_slot(head_reg))
                begin
                    head_next  = LINK_W'(tgt_reg);
                    prev_wdata = LINK_NIL;
                end
                else
                begin
                    next_we    = 1'b1;
                    next_waddr = tail_reg[CLIENT_W-1:0];
                    next_wdata = LINK_W'(tgt_reg);
                    prev_wdata = tail_reg;
                end
                tail_next  = LINK_W'(tgt_reg);
                state_next = ST_TERM;
            end

            ST_TERM:
            begin
                // new tail points nowhere
                next_we    = 1'b1;
                next_waddr = tgt_reg;
                next_wdata = LINK_NIL;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_next             = res_reg;
                    out_next.queue_count = count_reg;
                    out_next.queue_bytes = bytes_reg[QBYTES_W-1:0];
                    out_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
